// ----- design/cipm_pkg.sv -----
// Package for the content indicator pattern matcher.
// Holds the character types, the fixed pattern table and the byte normalizer.
// No dependencies.
package cipm_pkg;

  localparam int unsigned CharW     = 7;
  localparam int unsigned HistDepth = 13;
  localparam int unsigned WinLen    = HistDepth + 1;
  localparam int unsigned PatCount  = 11;
  localparam int unsigned FlagW     = 8;

  localparam logic [7:0] PrintLow  = 8'd32;
  localparam logic [7:0] PrintHigh = 8'd126;
  localparam logic [7:0] UpperLow  = 8'd65;
  localparam logic [7:0] UpperHigh = 8'd90;
  localparam logic [CharW-1:0] SpaceChar = 7'h20;
  localparam logic [CharW-1:0] CaseBit   = 7'h20;

  localparam int unsigned FlagStratum = 0;
  localparam int unsigned FlagMiner   = 1;
  localparam int unsigned FlagDonate  = 2;
  localparam int unsigned FlagCurl    = 3;
  localparam int unsigned FlagWget    = 4;
  localparam int unsigned FlagPipe    = 5;
  localparam int unsigned FlagChmod   = 6;
  localparam int unsigned FlagNohup   = 7;

  typedef logic [CharW-1:0] char_t;
  typedef char_t [WinLen-1:0] win_t;        // index 0 is the newest character
  typedef char_t [HistDepth-1:0] hist_t;
  typedef logic [8*WinLen-1:0] pat_text_t;  // last character in the low byte
  typedef logic [FlagW-1:0] flags_t;

  // Miner binary name, spelled as character codes.
  localparam pat_text_t MinerName = pat_text_t'({8'h78, 8'h6d, 8'h72, 8'h69, 8'h67});

  localparam pat_text_t PatText [PatCount] = '{
    pat_text_t'("stratum+tcp://"),
    pat_text_t'("stratum+ssl://"),
    MinerName,
    pat_text_t'("--donate-level"),
    pat_text_t'("curl "),
    pat_text_t'("wget "),
    pat_text_t'("| sh"),
    pat_text_t'("|sh"),
    pat_text_t'("| bash"),
    pat_text_t'("chmod +x"),
    pat_text_t'("nohup ")
  };

  localparam int unsigned PatLen [PatCount] = '{14, 14, 5, 14, 5, 5, 4, 3, 6, 8, 6};

  localparam int unsigned PatFlag [PatCount] = '{
    FlagStratum, FlagStratum, FlagMiner, FlagDonate, FlagCurl, FlagWget,
    FlagPipe, FlagPipe, FlagPipe, FlagChmod, FlagNohup
  };

  function automatic char_t normalize(input logic [7:0] b);
    char_t c;
    c = b[CharW-1:0];
    if (b < PrintLow || b > PrintHigh) begin
      c = SpaceChar;
    end else if (b >= UpperLow && b <= UpperHigh) begin
      c = b[CharW-1:0] | CaseBit;
    end
    return c;
  endfunction

endpackage

// ----- design/cipm_byte_if.sv -----
// Input channel of the pattern matcher: one file byte per request.
// Depends on nothing.
interface cipm_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

// ----- design/cipm_result_if.sv -----
// Result channel of the pattern matcher: flags and verdicts per file.
// Depends on nothing.
interface cipm_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] indicator_flags;
  logic       miner_compound;
  logic       stratum_only;
  logic       dropper_pattern;

  modport source (output valid, output indicator_flags, output miner_compound,
                  output stratum_only, output dropper_pattern, input ready);
  modport sink   (input valid, input indicator_flags, input miner_compound,
                  input stratum_only, input dropper_pattern, output ready);
endinterface

// ----- design/cipm_matcher.sv -----
// Parallel comparators of the character window against the pattern table.
// Depends on cipm_pkg.
module cipm_matcher (
  input  cipm_pkg::win_t   win,
  output cipm_pkg::flags_t hits
);

  always_comb begin
    cipm_pkg::pat_text_t txt;
    logic                hit;
    hits = '0;
    for (int p = 0; p < cipm_pkg::PatCount; p++) begin
      txt = cipm_pkg::PatText[p];
      hit = 1'b1;
      for (int k = 0; k < cipm_pkg::WinLen; k++) begin
        if (k < cipm_pkg::PatLen[p] && txt[8*k +: cipm_pkg::CharW] != win[k]) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        hits[cipm_pkg::PatFlag[p]] = 1'b1;
      end
    end
  end

endmodule

// ----- design/content_indicator_pattern_matcher_unit.sv -----
// Top level of the content indicator pattern matcher.
// Depends on cipm_pkg, cipm_byte_if, cipm_result_if and cipm_matcher.
//
// Usage:
//   data_chan carries one file byte per request, with end_of_file set on the
//   last byte of a file. Each byte is normalized (printable ASCII lower-cased,
//   anything else a space) and checked, together with the 13 characters before
//   it, against the fixed indicator patterns; hits set sticky flags.
//   On the last byte, result_chan presents one request with the flags and the
//   miner, stratum-only and dropper verdicts, and the history and flags clear.
//   Bytes that are not last produce nothing on result_chan.
// Timing:
//   One byte per cycle. The result appears in the cycle after the last byte is
//   taken, from the result register. Matching is a single level of parallel
//   byte comparators between the history register and that register.
// Stall:
//   data_chan.ready is low only while a result is held and not being taken;
//   while that result waits, the next byte waits with it.
// Reset:
//   rst (synchronous) clears the history, the flags and the result valid.
module content_indicator_pattern_matcher_unit (
  input logic           clk,
  input logic           rst,
  cipm_byte_if.sink     data_chan,
  cipm_result_if.source result_chan
);

  cipm_pkg::hist_t  hist;
  cipm_pkg::flags_t seen_flags;
  logic             res_valid;
  cipm_pkg::flags_t res_flags;
  logic             res_miner;
  logic             res_strat_only;
  logic             res_dropper;

  cipm_pkg::char_t  cur_char;
  cipm_pkg::win_t   win;
  cipm_pkg::flags_t hits;
  cipm_pkg::flags_t flags_now;
  logic             acc;
  logic             miner_now;

  assign data_chan.ready = !res_valid || result_chan.ready;
  assign acc             = data_chan.valid && data_chan.ready;
  assign cur_char        = cipm_pkg::normalize(data_chan.data_byte);
  assign win             = {hist, cur_char};
  assign flags_now       = seen_flags | hits;
  assign miner_now       = flags_now[cipm_pkg::FlagStratum] &&
                           (flags_now[cipm_pkg::FlagMiner] || flags_now[cipm_pkg::FlagDonate] ||
                            flags_now[cipm_pkg::FlagNohup]);

  cipm_matcher u_matcher (
    .win  (win),
    .hits (hits)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hist       <= '0;
      seen_flags <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (result_chan.valid && result_chan.ready) begin
        res_valid <= 1'b0;
      end
      if (acc) begin
        if (data_chan.end_of_file) begin
          hist       <= '0;
          seen_flags <= '0;
          res_valid  <= 1'b1;
        end else begin
          hist       <= {hist[cipm_pkg::HistDepth-2:0], cur_char};
          seen_flags <= flags_now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && data_chan.end_of_file) begin
      res_flags      <= flags_now;
      res_miner      <= miner_now;
      res_strat_only <= flags_now[cipm_pkg::FlagStratum] && !miner_now;
      res_dropper    <= (flags_now[cipm_pkg::FlagCurl] || flags_now[cipm_pkg::FlagWget]) &&
                        flags_now[cipm_pkg::FlagPipe] &&
                        (flags_now[cipm_pkg::FlagChmod] || flags_now[cipm_pkg::FlagNohup]);
    end
  end

  assign result_chan.valid           = res_valid;
  assign result_chan.indicator_flags = res_flags;
  assign result_chan.miner_compound  = res_miner;
  assign result_chan.stratum_only    = res_strat_only;
  assign result_chan.dropper_pattern = res_dropper;

  a_eof_gives_result: assert property (@(posedge clk) disable iff (rst)
    acc && data_chan.end_of_file |=> res_valid)
    else $error("last byte taken but no result registered");

  a_eof_clears: assert property (@(posedge clk) disable iff (rst)
    acc && data_chan.end_of_file |=> seen_flags == '0 && hist == '0)
    else $error("state not cleared after last byte");

  a_stall_only_when_held: assert property (@(posedge clk) disable iff (rst)
    !data_chan.ready |-> res_valid && !result_chan.ready)
    else $error("input stalled without a held result");

  a_verdicts_exclusive: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_miner && res_strat_only) &&
                  (res_miner || res_strat_only) == res_flags[cipm_pkg::FlagStratum])
    else $error("stratum verdicts inconsistent with flags");

endmodule

// ----- bench/tb_content_indicator_pattern_matcher_unit.sv -----
`timescale 1ns / 1ps
// Self-checking bench for content_indicator_pattern_matcher_unit: byte streams
// in, per-file indicator flags and verdicts out, checked against a local scanner.
// Depends on cipm_pkg, cipm_byte_if, cipm_result_if and the matcher RTL.
module tb_content_indicator_pattern_matcher_unit;

  localparam int unsigned RandomBytes = 2000;
  localparam int unsigned HoldAfter   = 40;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned CycleLimit  = 400000;

  localparam int unsigned SigFlag [cipm_pkg::PatCount] = '{
    cipm_pkg::FlagStratum, cipm_pkg::FlagStratum, cipm_pkg::FlagMiner,
    cipm_pkg::FlagDonate, cipm_pkg::FlagCurl, cipm_pkg::FlagWget,
    cipm_pkg::FlagPipe, cipm_pkg::FlagPipe, cipm_pkg::FlagPipe,
    cipm_pkg::FlagChmod, cipm_pkg::FlagNohup
  };

  typedef struct packed {
    cipm_pkg::flags_t flags;
    logic             miner;
    logic             strat_only;
    logic             dropper;
  } verdict_t;

  typedef struct packed {
    bit               typed;
    cipm_pkg::flags_t flags;
  } file_note_t;

  typedef struct {
    string            text;
    logic [7:0]       fill;
    bit               typed;
    cipm_pkg::flags_t flags;
  } file_row_t;

  logic clk;
  logic rst;

  cipm_byte_if   data_if ();
  cipm_result_if res_if ();

  content_indicator_pattern_matcher_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .data_chan   (data_if),
    .result_chan (res_if)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  verdict_t         verdict_q [$];
  file_note_t       file_note_q [$];
  cipm_pkg::char_t  scan_hist [cipm_pkg::HistDepth];
  cipm_pkg::flags_t scan_flags = '0;
  int unsigned      errors = 0;
  int unsigned      cycle_count = 0;
  int unsigned      sent_bytes = 0;
  int unsigned      files_checked = 0;
  int unsigned      miner_seen = 0;
  int unsigned      strat_only_seen = 0;
  int unsigned      dropper_seen = 0;
  cipm_pkg::flags_t flags_union = '0;
  bit               send_quiet = 1'b0;
  file_row_t        file_rows [22];

  initial begin
    foreach (scan_hist[k]) scan_hist[k] = '0;
  end

  function automatic string sig_text(int unsigned idx);
    case (idx)
      0:       return "stratum+tcp://";
      1:       return "stratum+ssl://";
      2:       return {"xmri", "g"};
      3:       return "--donate-level";
      4:       return "curl ";
      5:       return "wget ";
      6:       return "| sh";
      7:       return "|sh";
      8:       return "| bash";
      9:       return "chmod +x";
      default: return "nohup ";
    endcase
  endfunction

  function automatic cipm_pkg::char_t fold_char(logic [7:0] raw);
    if (raw < 8'd32 || raw > 8'd126) begin
      return 7'h20;
    end
    if (raw >= 8'd65 && raw <= 8'd90) begin
      return raw[6:0] + 7'd32;
    end
    return raw[6:0];
  endfunction

  function automatic verdict_t rate_flags(cipm_pkg::flags_t f);
    verdict_t v;
    v.flags      = f;
    v.miner      = f[cipm_pkg::FlagStratum] &&
                   (f[cipm_pkg::FlagMiner] || f[cipm_pkg::FlagDonate] ||
                    f[cipm_pkg::FlagNohup]);
    v.strat_only = f[cipm_pkg::FlagStratum] && !v.miner;
    v.dropper    = (f[cipm_pkg::FlagCurl] || f[cipm_pkg::FlagWget]) &&
                   f[cipm_pkg::FlagPipe] &&
                   (f[cipm_pkg::FlagChmod] || f[cipm_pkg::FlagNohup]);
    return v;
  endfunction

  // Matches the newest char plus history against every pattern, then shifts.
  function automatic void scan_byte(logic [7:0] raw, logic last);
    cipm_pkg::char_t win [cipm_pkg::WinLen];
    string           s;
    bit              hit;
    int              n;
    file_note_t      note;
    win[0] = fold_char(raw);
    for (int k = 1; k < cipm_pkg::WinLen; k++) win[k] = scan_hist[k-1];
    for (int p = 0; p < cipm_pkg::PatCount; p++) begin
      s   = sig_text(p);
      n   = s.len();
      hit = 1'b1;
      for (int k = 0; k < n; k++) begin
        if (s[n-1-k] != {1'b0, win[k]}) hit = 1'b0;
      end
      if (hit) scan_flags[SigFlag[p]] = 1'b1;
    end
    for (int k = cipm_pkg::HistDepth - 1; k > 0; k--) scan_hist[k] = scan_hist[k-1];
    scan_hist[0] = win[0];
    if (last) begin
      note = file_note_q.pop_front();
      verdict_q.push_back(rate_flags(note.typed ? note.flags : scan_flags));
      scan_flags = '0;
      foreach (scan_hist[k]) scan_hist[k] = '0;
    end
  endfunction

  task automatic check_verdict();
    verdict_t want;
    if (verdict_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, flags %h", $time, res_if.indicator_flags);
    end else begin
      want = verdict_q.pop_front();
      if (res_if.indicator_flags !== want.flags) begin
        errors++;
        $display("%0t: indicator_flags expected %h got %h", $time, want.flags,
                 res_if.indicator_flags);
      end
      if (res_if.miner_compound !== want.miner) begin
        errors++;
        $display("%0t: miner_compound expected %b got %b", $time, want.miner,
                 res_if.miner_compound);
      end
      if (res_if.stratum_only !== want.strat_only) begin
        errors++;
        $display("%0t: stratum_only expected %b got %b", $time, want.strat_only,
                 res_if.stratum_only);
      end
      if (res_if.dropper_pattern !== want.dropper) begin
        errors++;
        $display("%0t: dropper_pattern expected %b got %b", $time, want.dropper,
                 res_if.dropper_pattern);
      end
    end
    files_checked++;
    flags_union |= res_if.indicator_flags;
    if (res_if.miner_compound === 1'b1) miner_seen++;
    if (res_if.stratum_only === 1'b1) strat_only_seen++;
    if (res_if.dropper_pattern === 1'b1) dropper_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (res_if.valid && res_if.ready) check_verdict();
      if (data_if.valid && data_if.ready) begin
        scan_byte(data_if.data_byte, data_if.end_of_file);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] odd_byte();
    logic [7:0] b;
    if ($urandom_range(0, 1) == 1) b = 8'($urandom_range(0, 31));
    else b = 8'($urandom_range(127, 255));
    return b;
  endfunction

  // Appends a pattern with random case and some spaces swapped for unprintables;
  // a broken one is cut short or has one char replaced.
  task automatic add_sig(ref logic [7:0] bytes[$], input int unsigned idx,
                         input bit broken);
    string       s;
    int unsigned n, pos;
    bit          corrupt;
    logic [7:0]  c;
    s       = sig_text(idx);
    n       = s.len();
    corrupt = 1'b0;
    pos     = n;
    if (broken) begin
      if ($urandom_range(0, 1) == 1) begin
        n = $urandom_range(1, s.len() - 1);
      end else begin
        corrupt = 1'b1;
        pos     = $urandom_range(0, n - 1);
      end
    end
    for (int i = 0; i < n; i++) begin
      c = s[i];
      if (corrupt && i == pos) begin
        c = 8'd97 + 8'($urandom_range(0, 25));
      end else if (c >= 8'd97 && c <= 8'd122 && $urandom_range(0, 1) == 1) begin
        c = c - 8'd32;
      end else if (c == " " && $urandom_range(0, 2) == 0) begin
        c = odd_byte();
      end
      bytes.push_back(c);
    end
  endtask

  task automatic add_noise(ref logic [7:0] bytes[$], input int unsigned n);
    string      punct;
    logic [7:0] c;
    punct = " |+-:/.x";
    repeat (n) begin
      case ($urandom_range(0, 3))
        0:       c = 8'($urandom_range(0, 255));
        1:       c = 8'd97 + 8'($urandom_range(0, 25));
        2:       c = punct[$urandom_range(0, punct.len() - 1)];
        default: c = " ";
      endcase
      bytes.push_back(c);
    end
  endtask

  task automatic build_file(ref logic [7:0] bytes[$]);
    int unsigned style;
    bytes = {};
    style = $urandom_range(0, 9);
    if (style == 0) begin
      add_noise(bytes, $urandom_range(1, 3));
    end else if (style <= 3) begin
      add_noise(bytes, $urandom_range(0, 2));
      add_sig(bytes, $urandom_range(4, 5), $urandom_range(0, 4) == 0);
      add_noise(bytes, $urandom_range(0, 3));
      add_sig(bytes, $urandom_range(6, 8), $urandom_range(0, 4) == 0);
      add_noise(bytes, $urandom_range(0, 3));
      add_sig(bytes, $urandom_range(9, 10), $urandom_range(0, 4) == 0);
    end else if (style <= 5) begin
      add_sig(bytes, $urandom_range(0, 1), $urandom_range(0, 4) == 0);
      add_noise(bytes, $urandom_range(0, 3));
      case ($urandom_range(0, 3))
        0:       add_sig(bytes, 2, $urandom_range(0, 4) == 0);
        1:       add_sig(bytes, 3, $urandom_range(0, 4) == 0);
        2:       add_sig(bytes, 10, $urandom_range(0, 4) == 0);
        default: add_noise(bytes, 1);
      endcase
    end else begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 5))
          0, 1, 2: add_sig(bytes, $urandom_range(0, cipm_pkg::PatCount - 1), 1'b0);
          3:       add_sig(bytes, $urandom_range(0, cipm_pkg::PatCount - 1), 1'b1);
          default: add_noise(bytes, $urandom_range(1, 6));
        endcase
      end
    end
    if (bytes.size() == 0) add_noise(bytes, 1);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = send_quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      data_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    data_if.valid       <= 1'b1;
    data_if.data_byte   <= b;
    data_if.end_of_file <= last;
    do @(posedge clk); while (!data_if.ready);
    sent_bytes++;
  endtask

  task automatic send_file(input logic [7:0] bytes[$], input bit typed,
                           input cipm_pkg::flags_t flags);
    file_note_t note;
    note.typed = typed;
    note.flags = flags;
    file_note_q.push_back(note);
    if ($urandom_range(0, 7) == 0) send_quiet = !send_quiet;
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  task automatic drain_pause();
    data_if.valid <= 1'b0;
    @(negedge clk);
    wait (verdict_q.size() == 0);
    @(posedge clk);
  endtask

  initial begin : result_sink
    int unsigned taken, stall;
    bit          quiet, held;
    taken = 0;
    quiet = 1'b0;
    held  = 1'b0;
    res_if.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (taken == HoldAfter && !held) begin
        held = 1'b1;
        res_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      if ($urandom_range(0, 15) == 0) quiet = !quiet;
      stall = quiet ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
      taken++;
    end
  end

  initial begin : byte_source
    logic [7:0]  file_bytes [$];
    string       t;
    logic [7:0]  c;
    int unsigned files_sent, target;
    rst                 <= 1'b1;
    data_if.valid       <= 1'b0;
    data_if.data_byte   <= '0;
    data_if.end_of_file <= 1'b0;
    // '#' stands for the fill byte of its row
    file_rows = '{
      '{"a",                       8'h00, 1'b1, 8'h00},
      '{"#",                       8'h00, 1'b1, 8'h00},
      '{"#",                       8'hFF, 1'b1, 8'h00},
      '{"A#Z@[{~",                 8'h80, 1'b1, 8'h00},
      '{"stratum+tcp://",          8'h00, 1'b1, 8'h01},
      '{"STRATUM+SSL://",          8'h00, 1'b1, 8'h01},
      '{"xmri#",                   8'h67, 1'b1, 8'h02},
      '{"--DONATE-LEVEL",          8'h00, 1'b1, 8'h04},
      '{"curl#",                   8'h00, 1'b1, 8'h08},
      '{"WGET#",                   8'h7F, 1'b1, 8'h10},
      '{"| sh",                    8'h00, 1'b1, 8'h20},
      '{"|SH",                     8'h00, 1'b1, 8'h20},
      '{"#| bash",                 8'h1F, 1'b1, 8'h20},
      '{"chmod +x",                8'h00, 1'b1, 8'h40},
      '{"nohup#",                  8'hFF, 1'b1, 8'h80},
      '{"stratum+tc",              8'h00, 1'b1, 8'h00},
      '{"p://",                    8'h00, 1'b1, 8'h00},
      '{"stratum+tcp:/",           8'h00, 1'b1, 8'h00},
      '{"curl x | sh; chmod +x y", 8'h00, 1'b0, 8'h00},
      '{"stratum+ssl://h nohup a", 8'h00, 1'b0, 8'h00},
      '{"wget -o-|bash nohup ",    8'h00, 1'b0, 8'h00},
      '{"stratum+tcp://p xmri#",   8'h47, 1'b0, 8'h00}
    };
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (file_rows[r]) begin
      file_bytes = {};
      t = file_rows[r].text;
      for (int k = 0; k < t.len(); k++) begin
        c = t[k];
        file_bytes.push_back(c == "#" ? file_rows[r].fill : c);
      end
      send_file(file_bytes, file_rows[r].typed, file_rows[r].flags);
    end
    drain_pause();

    files_sent = 0;
    target     = sent_bytes + RandomBytes;
    while (sent_bytes < target) begin
      build_file(file_bytes);
      send_file(file_bytes, 1'b0, '0);
      files_sent++;
      if (files_sent % 25 == 0) drain_pause();
    end
    data_if.valid <= 1'b0;

    @(negedge clk);
    wait (verdict_q.size() == 0);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d bytes, checked %0d files; flags seen %b", sent_bytes,
             files_checked, flags_union);
    $display("Verdicts raised: miner %0d, stratum-only %0d, dropper %0d",
             miner_seen, strat_only_seen, dropper_seen);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/cipm_pkg.sv
design/cipm_byte_if.sv
design/cipm_result_if.sv
design/cipm_matcher.sv
design/content_indicator_pattern_matcher_unit.sv
bench/tb_content_indicator_pattern_matcher_unit.sv
